// ===== rtl/hbew_pkg.sv =====
// Package for the hydrogen-bond ellipsoid overlap weight unit.
// Payload structs, register indexes, fixed widths and the square-root step.
// No dependencies.
package hbew_pkg;

  // Field widths and fixed-point layout
  localparam int POS_WIDTH      = 20;
  localparam int DIR_FRAC_BITS  = 14;
  localparam int DIR_WIDTH      = DIR_FRAC_BITS + 2;
  localparam int POS_FRAC_BITS  = 10;
  localparam int CFG_WIDTH      = 24;
  localparam int CFG_IDX_WIDTH  = 2;

  // Internal widths
  localparam int DIFF_W  = POS_WIDTH + 1;       // full difference
  localparam int DS_W    = 14;                  // difference once known near
  localparam int SQD_W   = 26;                  // one squared component
  localparam int N_W     = 28;                  // squared distance
  localparam int PMD_W   = DS_W + DIR_WIDTH;    // d * model_dir
  localparam int DOT_W   = DIR_WIDTH + 15;      // out-of-plane sum, signed
  localparam int PDD_W   = 2 * DIR_WIDTH;       // dir * dir
  localparam int DD_W    = 2 * DIR_WIDTH + 1;   // direction dot, signed
  localparam int OOP_SH  = DIR_FRAC_BITS + POS_FRAC_BITS - 16;
  localparam int DD_SH   = 2 * DIR_FRAC_BITS - 16;
  localparam int OQ_W    = 22;
  localparam int DMAG_W  = DD_W - 1 - DD_SH;
  localparam int RAD_W   = 48;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = ROOT_W + 2;
  localparam int SQ_STEPS_PER_STAGE = 4;
  localparam int SQ_STAGES = ROOT_W / SQ_STEPS_PER_STAGE;
  localparam int BMAG_W  = 24;
  localparam int PROD_W  = BMAG_W + DMAG_W;

  localparam logic [DIFF_W-1:0] FAR_POS = DIFF_W'(8192);
  localparam logic [DIFF_W-1:0] FAR_NEG = DIFF_W'(-8192);
  localparam logic [ROOT_W-1:0] T_ONE   = ROOT_W'(65536);
  localparam logic [ROOT_W-1:0] T_TWO   = ROOT_W'(131072);
  localparam logic [BMAG_W-1:0] BASE_ONE = BMAG_W'(65536);
  localparam logic [15:0] WEIGHT_ONE = 16'd32768;

  // Configuration register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_MAX_DIST_SQ = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_MAX_OOP     = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_NEAR_DIST_SQ = 2'd2;

  typedef struct packed {
    logic signed [POS_WIDTH-1:0] model_x;
    logic signed [POS_WIDTH-1:0] model_y;
    logic signed [POS_WIDTH-1:0] model_z;
    logic signed [DIR_WIDTH-1:0] model_dir_x;
    logic signed [DIR_WIDTH-1:0] model_dir_y;
    logic signed [DIR_WIDTH-1:0] model_dir_z;
    logic signed [POS_WIDTH-1:0] search_x;
    logic signed [POS_WIDTH-1:0] search_y;
    logic signed [POS_WIDTH-1:0] search_z;
    logic signed [DIR_WIDTH-1:0] search_dir_x;
    logic signed [DIR_WIDTH-1:0] search_dir_y;
    logic signed [DIR_WIDTH-1:0] search_dir_z;
  } in_item_t;

  typedef struct packed {
    logic        in_range;
    logic [15:0] weight;
  } out_item_t;

  // Flags that ride along the back half of the pipeline
  typedef struct packed {
    logic              rng;
    logic              near;
    logic              dd_pos;
    logic              dd_neg;
    logic [DMAG_W-1:0] dmag;
  } side_t;

  // Restoring square-root state
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sq_t;

  // Four digit steps of floor(sqrt(rad)), two radicand bits per step
  function automatic sq_t sqrt_step4(sq_t s);
    sq_t                o;
    logic [REM_W+1:0]   rem_sh;
    logic [REM_W+1:0]   trial;
    o = s;
    for (int i = 0; i < SQ_STEPS_PER_STAGE; i++) begin
      rem_sh = {o.rem, o.rad[RAD_W-1:RAD_W-2]};
      trial  = {2'b00, o.root, 2'b01};
      o.rad  = {o.rad[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_sh = rem_sh - trial;
        o.root = {o.root[ROOT_W-2:0], 1'b1};
      end else begin
        o.root = {o.root[ROOT_W-2:0], 1'b0};
      end
      o.rem = rem_sh[REM_W-1:0];
    end
    return o;
  endfunction

endpackage

// ===== rtl/hbond_ellipsoid_overlap_weight_unit.sv =====
// Hydrogen-bond ellipsoid overlap weight unit, top level.
// Depends on hbew_pkg.
//
// Takes one model/search point pair per transaction and returns one result:
// in_range and an overlap weight in Q.15. The unit is fully pipelined: one
// transaction per cycle while the output is not stalled. The 24-digit
// square root is spread over six stages of four steps. Each stage holds its
// item while the stage after it is full and stalled, so a stall loses nothing
// and empty stages close up. The user must write limits over the cfg port
// only while no transaction is in flight; the unit does not enforce this.
module hbond_ellipsoid_overlap_weight_unit
  import hbew_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]     cfg_data
);

  localparam int NS = 15;
  localparam int SQ0 = 6;   // first square-root stage

  // Configuration registers
  logic [23:0] max_dist_sq_r;
  logic [15:0] max_oop_r;
  logic [23:0] near_dist_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dist_sq_r  <= 24'd4194304;
      max_oop_r      <= 16'd1024;
      near_dist_sq_r <= 24'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_DIST_SQ:  max_dist_sq_r  <= cfg_data;
        CFG_MAX_OOP:      max_oop_r      <= cfg_data[15:0];
        CFG_NEAR_DIST_SQ: near_dist_sq_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits and per-stage enables
  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[NS-1];

  // Stage 0: differences and far-coordinate check
  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic                     far_nxt;
  logic signed [DS_W-1:0]   d_r [3];
  logic signed [DIR_WIDTH-1:0] md_r [3];
  logic signed [DIR_WIDTH-1:0] sd_r [3];
  logic                     far_r;

  always_comb begin
    dx = DIFF_W'(in_data.search_x) - DIFF_W'(in_data.model_x);
    dy = DIFF_W'(in_data.search_y) - DIFF_W'(in_data.model_y);
    dz = DIFF_W'(in_data.search_z) - DIFF_W'(in_data.model_z);
    far_nxt = (dx >= $signed(FAR_POS)) || (dx <= $signed(FAR_NEG)) ||
              (dy >= $signed(FAR_POS)) || (dy <= $signed(FAR_NEG)) ||
              (dz >= $signed(FAR_POS)) || (dz <= $signed(FAR_NEG));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d_r[0]  <= dx[DS_W-1:0];
      d_r[1]  <= dy[DS_W-1:0];
      d_r[2]  <= dz[DS_W-1:0];
      md_r[0] <= in_data.model_dir_x;
      md_r[1] <= in_data.model_dir_y;
      md_r[2] <= in_data.model_dir_z;
      sd_r[0] <= in_data.search_dir_x;
      sd_r[1] <= in_data.search_dir_y;
      sd_r[2] <= in_data.search_dir_z;
      far_r   <= far_nxt;
    end
  end

  // Stage 1: component products
  logic [SQD_W-1:0]         sqd_r [3];
  logic signed [PMD_W-1:0]  pmd_r [3];
  logic signed [PDD_W-1:0]  pdd_r [3];
  logic                     far1_r;
  logic signed [2*DS_W-1:0] sq_full [3];

  always_comb begin
    for (int i = 0; i < 3; i++) sq_full[i] = d_r[i] * d_r[i];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        sqd_r[i] <= sq_full[i][SQD_W-1:0];
        pmd_r[i] <= PMD_W'(d_r[i]) * PMD_W'(md_r[i]);
        pdd_r[i] <= PDD_W'(md_r[i]) * PDD_W'(sd_r[i]);
      end
      far1_r <= far_r;
    end
  end

  // Stage 2: sums
  logic [N_W-1:0]          n_r;
  logic signed [DOT_W-1:0] dot_r;
  logic signed [DD_W-1:0]  dd_r;
  logic                    far2_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      n_r    <= N_W'(sqd_r[0]) + N_W'(sqd_r[1]) + N_W'(sqd_r[2]);
      dot_r  <= DOT_W'(pmd_r[0]) + DOT_W'(pmd_r[1]) + DOT_W'(pmd_r[2]);
      dd_r   <= DD_W'(pdd_r[0]) + DD_W'(pdd_r[1]) + DD_W'(pdd_r[2]);
      far2_r <= far1_r;
    end
  end

  // Stage 3: limit checks and scaling
  logic [DOT_W-2:0]  absdot;
  logic [DD_W-2:0]   absdd;
  logic [DOT_W-2:0]  oop_lim;
  side_t             side_nxt;
  side_t             side_r [SQ0+SQ_STAGES-2:3];
  logic [OQ_W-1:0]   oq_r;
  logic [23:0]       n3_r;

  always_comb begin
    absdot  = dot_r[DOT_W-1] ? (DOT_W-1)'(-dot_r) : (DOT_W-1)'(dot_r);
    absdd   = dd_r[DD_W-1] ? (DD_W-1)'(-dd_r) : (DD_W-1)'(dd_r);
    oop_lim = {max_oop_r, {DIR_FRAC_BITS{1'b0}}};
    side_nxt.rng    = !far2_r && (n_r <= N_W'(max_dist_sq_r)) && (absdot <= oop_lim);
    side_nxt.near   = n_r < N_W'(near_dist_sq_r);
    side_nxt.dd_pos = !dd_r[DD_W-1] && (dd_r != '0);
    side_nxt.dd_neg = dd_r[DD_W-1];
    side_nxt.dmag   = absdd[DD_W-2:DD_SH];
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      side_r[3] <= side_nxt;
      oq_r      <= absdot[OQ_W+OOP_SH-1:OOP_SH];
      n3_r      <= n_r[23:0];
    end
  end

  // Stage 4: square of out-of-plane term
  logic [2*OQ_W-1:0] oq2_r;
  logic [23:0]       n4_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      oq2_r     <= oq_r * oq_r;
      n4_r      <= n3_r;
      side_r[4] <= side_r[3];
    end
  end

  // Stage 5: radicand 3*oop^2 + n*2^12
  logic [RAD_W-1:0] rad_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      rad_r     <= RAD_W'(oq2_r) + RAD_W'({oq2_r, 1'b0}) + {12'd0, n4_r, 12'd0};
      side_r[5] <= side_r[4];
    end
  end

  // Stages 6..11: square root, four digits per stage
  sq_t sq_r [SQ_STAGES];

  for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sqrt
    sq_t sq_in;
    if (j == 0) begin : g_first
      assign sq_in = '{rem: '0, root: '0, rad: rad_r};
    end else begin : g_next
      assign sq_in = sq_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (en[SQ0+j]) sq_r[j] <= sqrt_step4(sq_in);
    end
    if (j < SQ_STAGES - 1) begin : g_side
      always_ff @(posedge clk) begin
        if (en[SQ0+j]) side_r[SQ0+j] <= side_r[SQ0+j-1];
      end
    end
  end

  side_t side11_r;
  always_ff @(posedge clk) begin
    if (en[SQ0+SQ_STAGES-1]) side11_r <= side_r[SQ0+SQ_STAGES-2];
  end

  // Stage 12: base value from 2*ratio
  logic [ROOT_W-1:0] t;
  logic [BMAG_W-1:0] bmag_nxt;
  logic              bpos_nxt, bneg_nxt;
  logic [BMAG_W-1:0] bmag_r;
  logic              pos_r, rng12_r;
  logic [DMAG_W-1:0] dmag12_r;

  always_comb begin
    t = sq_r[SQ_STAGES-1].root;
    bmag_nxt = BASE_ONE;
    bpos_nxt = 1'b1;
    bneg_nxt = 1'b0;
    if (!side11_r.near && t > T_ONE) begin
      if (t < T_TWO) begin
        bmag_nxt = T_TWO - t;
      end else if (t == T_TWO) begin
        bmag_nxt = '0;
        bpos_nxt = 1'b0;
      end else begin
        bmag_nxt = t - T_TWO;
        bpos_nxt = 1'b0;
        bneg_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[12]) begin
      bmag_r   <= bmag_nxt;
      pos_r    <= (bpos_nxt && side11_r.dd_pos) || (bneg_nxt && side11_r.dd_neg);
      rng12_r  <= side11_r.rng;
      dmag12_r <= side11_r.dmag;
    end
  end

  // Stage 13: weight product
  logic [PROD_W-1:0] prod_r;
  logic              ok13_r, rng13_r;

  always_ff @(posedge clk) begin
    if (en[13]) begin
      prod_r  <= PROD_W'(bmag_r) * PROD_W'(dmag12_r);
      ok13_r  <= pos_r && rng12_r;
      rng13_r <= rng12_r;
    end
  end

  // Stage 14: scale, saturate, output register
  logic [PROD_W-18:0] wq;
  out_item_t          out_nxt;
  out_item_t          out_r;

  always_comb begin
    wq = prod_r[PROD_W-1:17];
    out_nxt.in_range = rng13_r;
    if (!ok13_r) begin
      out_nxt.weight = '0;
    end else if (wq > (PROD_W-17)'(WEIGHT_ONE)) begin
      out_nxt.weight = WEIGHT_ONE;
    end else begin
      out_nxt.weight = wq[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[14]) out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule

// ===== rtl/hbew_checker.sv =====
// Port-level checker for the overlap weight unit, with its bind.
// Depends on hbew_pkg.
module hbew_checker
  import hbew_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Out-of-range pairs carry zero weight
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.in_range |-> out_data.weight == 16'd0)
    else $error("nonzero weight out of range");

  // Weight never exceeds one
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.weight <= WEIGHT_ONE)
    else $error("weight above one");

  // Input is only held off while a result waits
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

endmodule

bind hbond_ellipsoid_overlap_weight_unit hbew_checker u_hbew_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
